[hw/rtl/sfag_pkg.sv]
package sfag_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int EXT_CFG_W  = 16;
	localparam int STRIDE_W   = 24;
	localparam int BASE_W     = 24;
	localparam int VALUE_W    = 64;
	localparam int COUNT_W    = 48;
	localparam int OUT_ADDR_W = 32;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_CONTIG        = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE          = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_OUTER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_MIDDLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EXTENT_INNER  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_OUTER  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_MIDDLE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE_INNER  = 3'd7;

	// step control broadcast to every cell of the odometer
	typedef struct packed {
		logic step;
		logic clear;
		logic wrap;
	} sfag_ctrl_t;

	// fixed-width part of a word in flight between the cells and the output stage
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic [COUNT_W-1:0] count;
	} sfag_item_t;

endpackage

[hw/rtl/strided_fill_address_generator.sv]
// a word accepted on the input is registered in the product stage and then in the output register
// throughput: one word per cycle unless the output stalls, set by the odometer carry
// running through the row of coordinate cells and being committed in the same cycle
// a stalled output holds its word while one more word waits in the product stage
// reset clears coordinates, linear count and valid flags, and loads the register defaults
module strided_fill_address_generator #(
	parameter int NUM_DIMS     = 3,
	parameter int ADDR_WIDTH   = 32,
	parameter int EXTENT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write_enable,
	input  logic [sfag_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [sfag_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sfag_pkg::VALUE_W-1:0]      fill_value,
	input  logic                              restart,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sfag_pkg::OUT_ADDR_W-1:0]   write_address,
	output logic [sfag_pkg::VALUE_W-1:0]      write_value,
	output logic                              last_element,
	output logic                              overflow
);
	import sfag_pkg::*;

	localparam int NCELL  = 3;
	localparam int PROD_W = EXTENT_WIDTH + STRIDE_W;

	logic                 contiguous_q;
	logic [BASE_W-1:0]    base_q;
	logic [EXT_CFG_W-1:0] extent_q [NCELL];
	logic [STRIDE_W-1:0]  stride_q [NCELL];

	logic [COUNT_W-1:0]   count_q;
	logic [COUNT_W-1:0]   count;
	logic                 accept;
	logic                 last;
	logic                 take;
	logic [NCELL:0]       carry;
	logic [PROD_W-1:0]    prod_s1 [NCELL];
	sfag_ctrl_t           ctrl;
	logic                 valid_s1;
	sfag_item_t           item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			contiguous_q <= 1'b0;
			base_q       <= '0;
			extent_q[0]  <= EXT_CFG_W'(1);
			extent_q[1]  <= EXT_CFG_W'(1);
			extent_q[2]  <= EXT_CFG_W'(1);
			stride_q[0]  <= '0;
			stride_q[1]  <= '0;
			stride_q[2]  <= STRIDE_W'(1);
		end else if (cfg_write_enable) begin
			unique case (cfg_index)
				REG_CONTIG:        contiguous_q <= cfg_data[0];
				REG_BASE:          base_q       <= cfg_data[BASE_W-1:0];
				REG_EXTENT_OUTER:  extent_q[0]  <= cfg_data[EXT_CFG_W-1:0];
				REG_EXTENT_MIDDLE: extent_q[1]  <= cfg_data[EXT_CFG_W-1:0];
				REG_EXTENT_INNER:  extent_q[2]  <= cfg_data[EXT_CFG_W-1:0];
				REG_STRIDE_OUTER:  stride_q[0]  <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_MIDDLE: stride_q[1]  <= cfg_data[STRIDE_W-1:0];
				REG_STRIDE_INNER:  stride_q[2]  <= cfg_data[STRIDE_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = !valid_s1 || take;
	assign accept   = in_valid && in_ready;

	// carry enters at the inner cell; out of the outer cell it marks the last element
	assign carry[NCELL] = 1'b1;
	assign last         = carry[0];

	assign ctrl.step  = accept;
	assign ctrl.clear = restart;
	assign ctrl.wrap  = last;

	for (genvar d = 0; d < NCELL; d++) begin : g_cell
		sfag_cell #(
			.EXTENT_WIDTH (EXTENT_WIDTH),
			.USED         (d >= NCELL - NUM_DIMS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.carry_in   (carry[d+1]),
			.extent     (extent_q[d]),
			.stride     (stride_q[d]),
			.carry_out  (carry[d]),
			.product_s1 (prod_s1[d])
		);
	end

	assign count = restart ? '0 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= last ? '0 : count + COUNT_W'(1);
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.value <= fill_value;
			item_s1.last  <= last;
			item_s1.count <= count;
		end
	end

	sfag_out #(
		.ADDR_WIDTH (ADDR_WIDTH),
		.PROD_W     (PROD_W)
	) u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.item_s1        (item_s1),
		.prod_outer_s1  (prod_s1[0]),
		.prod_middle_s1 (prod_s1[1]),
		.prod_inner_s1  (prod_s1[2]),
		.contiguous     (contiguous_q),
		.base           (base_q),
		.out_ready      (out_ready),
		.take           (take),
		.out_valid      (out_valid),
		.write_address  (write_address),
		.write_value    (write_value),
		.last_element   (last_element),
		.overflow       (overflow)
	);

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

	a_wrap_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> count_q == '0)
		else $error("linear count not cleared after the last element");

	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		accept && restart && !last |=> count_q == COUNT_W'(1))
		else $error("restart did not begin the pass at the first element");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !take |=> valid_s1 && $stable(item_s1))
		else $error("product stage word lost during output stall");

endmodule

[hw/rtl/sfag_cell.sv]
module sfag_cell #(
	parameter int EXTENT_WIDTH = 16,
	parameter bit USED         = 1'b1
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  sfag_pkg::sfag_ctrl_t                         ctrl,
	input  logic                                         carry_in,
	input  logic [sfag_pkg::EXT_CFG_W-1:0]               extent,
	input  logic [sfag_pkg::STRIDE_W-1:0]                stride,
	output logic                                         carry_out,
	output logic [EXTENT_WIDTH+sfag_pkg::STRIDE_W-1:0]   product_s1
);
	import sfag_pkg::*;

	localparam int PROD_W = EXTENT_WIDTH + STRIDE_W;

	logic [EXTENT_WIDTH-1:0] coord_q;
	logic [EXTENT_WIDTH-1:0] coord;
	logic [EXTENT_WIDTH-1:0] coord_next;
	logic [EXTENT_WIDTH-1:0] ext_raw;
	logic [EXTENT_WIDTH-1:0] ext_eff;
	logic                    at_end;

	assign ext_raw = EXTENT_WIDTH'(extent);
	assign ext_eff = (ext_raw == '0) ? EXTENT_WIDTH'(1) : ext_raw;

	// an unused dimension acts as extent one, coordinate zero
	assign coord  = (!USED || ctrl.clear) ? '0 : coord_q;
	assign at_end = !USED || (coord >= ext_eff - EXTENT_WIDTH'(1));

	assign carry_out = carry_in & at_end;

	always_comb begin
		if (ctrl.wrap || (carry_in && at_end)) begin
			coord_next = '0;
		end else if (carry_in) begin
			coord_next = coord + EXTENT_WIDTH'(1);
		end else begin
			coord_next = coord;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coord_q <= '0;
		end else if (ctrl.step) begin
			coord_q <= coord_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			product_s1 <= PROD_W'(coord) * PROD_W'(stride);
		end
	end

endmodule

[hw/rtl/sfag_out.sv]
module sfag_out #(
	parameter int ADDR_WIDTH = 32,
	parameter int PROD_W     = 40
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              valid_s1,
	input  sfag_pkg::sfag_item_t              item_s1,
	input  logic [PROD_W-1:0]                 prod_outer_s1,
	input  logic [PROD_W-1:0]                 prod_middle_s1,
	input  logic [PROD_W-1:0]                 prod_inner_s1,
	input  logic                              contiguous,
	input  logic [sfag_pkg::BASE_W-1:0]       base,
	input  logic                              out_ready,
	output logic                              take,
	output logic                              out_valid,
	output logic [sfag_pkg::OUT_ADDR_W-1:0]   write_address,
	output logic [sfag_pkg::VALUE_W-1:0]      write_value,
	output logic                              last_element,
	output logic                              overflow
);
	import sfag_pkg::*;

	localparam int SUM_W = ((PROD_W + 2) > (COUNT_W + 1)) ? (PROD_W + 2) : (COUNT_W + 1);
	localparam int KEEP_W = (ADDR_WIDTH < OUT_ADDR_W) ? ADDR_WIDTH : OUT_ADDR_W;

	logic                  out_valid_q;
	logic [OUT_ADDR_W-1:0] write_address_q;
	logic [VALUE_W-1:0]    write_value_q;
	logic                  last_element_q;
	logic                  overflow_q;
	logic [SUM_W-1:0]      sum;

	always_comb begin
		if (contiguous) begin
			sum = SUM_W'(base) + SUM_W'(item_s1.count);
		end else begin
			sum = SUM_W'(base) + SUM_W'(prod_outer_s1) + SUM_W'(prod_middle_s1)
				+ SUM_W'(prod_inner_s1);
		end
	end

	assign take = valid_s1 && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			write_address_q <= OUT_ADDR_W'(sum[KEEP_W-1:0]);
			write_value_q   <= item_s1.value;
			last_element_q  <= item_s1.last;
			overflow_q      <= |sum[SUM_W-1:ADDR_WIDTH];
		end
	end

	assign out_valid     = out_valid_q;
	assign write_address = write_address_q;
	assign write_value   = write_value_q;
	assign last_element  = last_element_q;
	assign overflow      = overflow_q;

endmodule

[bench/sfag_write_checker.sv]
module sfag_write_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_write_enable,
	input  logic [sfag_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfag_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [sfag_pkg::VALUE_W-1:0]    fill_value,
	input  logic                            restart,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [sfag_pkg::OUT_ADDR_W-1:0] write_address,
	input  logic [sfag_pkg::VALUE_W-1:0]    write_value,
	input  logic                            last_element,
	input  logic                            overflow,
	output int                              mismatches,
	output int                              words_in_flight
);
	import sfag_pkg::*;

	typedef struct {
		logic [OUT_ADDR_W-1:0] addr;
		logic [VALUE_W-1:0]    value;
		logic                  last;
		logic                  ovf;
	} fill_write_t;

	// view registers as the block should hold them
	logic                 view_contig;
	logic [BASE_W-1:0]    view_base;
	logic [EXT_CFG_W-1:0] ext_outer, ext_middle, ext_inner;
	logic [STRIDE_W-1:0]  step_outer, step_middle, step_inner;

	// odometer position
	logic [EXT_CFG_W-1:0] pos_outer, pos_middle, pos_inner;
	logic [COUNT_W-1:0]   elem_count;

	fill_write_t expected_writes[$];
	fill_write_t want;

	function automatic fill_write_t next_fill_write(input logic [VALUE_W-1:0] value,
			input logic fresh);
		logic [EXT_CFG_W:0] lim_o, lim_m, lim_i;
		logic [63:0]        addr;
		logic               end_o, end_m, end_i;
		fill_write_t        w;
		// a zero extent behaves as one
		lim_o = (ext_outer == '0) ? (EXT_CFG_W+1)'(1) : {1'b0, ext_outer};
		lim_m = (ext_middle == '0) ? (EXT_CFG_W+1)'(1) : {1'b0, ext_middle};
		lim_i = (ext_inner == '0) ? (EXT_CFG_W+1)'(1) : {1'b0, ext_inner};
		if (fresh) begin
			pos_outer = '0;
			pos_middle = '0;
			pos_inner = '0;
			elem_count = '0;
		end
		if (view_contig)
			addr = 64'(view_base) + 64'(elem_count);
		else
			addr = 64'(view_base) + 64'(pos_outer) * 64'(step_outer)
				+ 64'(pos_middle) * 64'(step_middle) + 64'(pos_inner) * 64'(step_inner);
		// a coordinate left past a shrunken extent still counts as at its end
		end_o = {1'b0, pos_outer} >= lim_o - 1;
		end_m = {1'b0, pos_middle} >= lim_m - 1;
		end_i = {1'b0, pos_inner} >= lim_i - 1;
		w.addr = addr[OUT_ADDR_W-1:0];
		w.value = value;
		w.last = end_o && end_m && end_i;
		w.ovf = addr > 64'hFFFF_FFFF;
		if (w.last) begin
			pos_outer = '0;
			pos_middle = '0;
			pos_inner = '0;
			elem_count = '0;
		end else begin
			elem_count = elem_count + 1'b1;
			if (!end_i) begin
				pos_inner = pos_inner + 1'b1;
			end else begin
				pos_inner = '0;
				if (!end_m) begin
					pos_middle = pos_middle + 1'b1;
				end else begin
					pos_middle = '0;
					pos_outer = pos_outer + 1'b1;
				end
			end
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			view_contig = 1'b0;
			view_base = '0;
			ext_outer = EXT_CFG_W'(1);
			ext_middle = EXT_CFG_W'(1);
			ext_inner = EXT_CFG_W'(1);
			step_outer = '0;
			step_middle = '0;
			step_inner = STRIDE_W'(1);
			pos_outer = '0;
			pos_middle = '0;
			pos_inner = '0;
			elem_count = '0;
			expected_writes.delete();
			mismatches = 0;
			words_in_flight <= 0;
		end else begin
			if (cfg_write_enable) begin
				case (cfg_index)
					REG_CONTIG:        view_contig = cfg_data[0];
					REG_BASE:          view_base = cfg_data[BASE_W-1:0];
					REG_EXTENT_OUTER:  ext_outer = cfg_data[EXT_CFG_W-1:0];
					REG_EXTENT_MIDDLE: ext_middle = cfg_data[EXT_CFG_W-1:0];
					REG_EXTENT_INNER:  ext_inner = cfg_data[EXT_CFG_W-1:0];
					REG_STRIDE_OUTER:  step_outer = cfg_data[STRIDE_W-1:0];
					REG_STRIDE_MIDDLE: step_middle = cfg_data[STRIDE_W-1:0];
					REG_STRIDE_INNER:  step_inner = cfg_data[STRIDE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_writes.insert(expected_writes.size(),
					next_fill_write(fill_value, restart));
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected word addr %h value %h last %b ovf %b",
							$realtime, write_address, write_value, last_element, overflow);
				end else begin
					want = expected_writes.pop_front();
					if (write_address !== want.addr || write_value !== want.value
							|| last_element !== want.last || overflow !== want.ovf) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: word mismatch addr %h/%h value %h/%h %s",
								$realtime, want.addr, write_address, want.value,
								write_value,
								$sformatf("last %b/%b ovf %b/%b", want.last,
									last_element, want.ovf, overflow));
					end
				end
			end
			words_in_flight <= expected_writes.size();
		end
	end

endmodule

[bench/tb_strided_fill_address_generator.sv]
module tb_strided_fill_address_generator;
	import sfag_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_ITEMS = 700;
	localparam logic [BASE_W-1:0]    BASE_MAX = '1;
	localparam logic [STRIDE_W-1:0]  STRIDE_MAX = '1;
	localparam logic [EXT_CFG_W-1:0] EXTENT_MAX = '1;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write_enable;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [VALUE_W-1:0]    fill_value;
	logic                  restart;
	logic                  out_valid;
	logic                  out_ready;
	logic [OUT_ADDR_W-1:0] write_address;
	logic [VALUE_W-1:0]    write_value;
	logic                  last_element;
	logic                  overflow;

	int mismatches;
	int words_in_flight;
	int cycles;
	bit gaps_on;

	strided_fill_address_generator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.fill_value       (fill_value),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.write_address    (write_address),
		.write_value      (write_value),
		.last_element     (last_element),
		.overflow         (overflow)
	);

	sfag_write_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_enable (cfg_write_enable),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.fill_value       (fill_value),
		.restart          (restart),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.write_address    (write_address),
		.write_value      (write_value),
		.last_element     (last_element),
		.overflow         (overflow),
		.mismatches       (mismatches),
		.words_in_flight  (words_in_flight)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write_enable <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic program_view(input logic contig, input logic [BASE_W-1:0] base,
			input logic [EXT_CFG_W-1:0] eo, em, ei,
			input logic [STRIDE_W-1:0] so, sm, si);
		write_reg(REG_CONTIG, CFG_DATA_W'(contig));
		write_reg(REG_BASE, CFG_DATA_W'(base));
		write_reg(REG_EXTENT_OUTER, CFG_DATA_W'(eo));
		write_reg(REG_EXTENT_MIDDLE, CFG_DATA_W'(em));
		write_reg(REG_EXTENT_INNER, CFG_DATA_W'(ei));
		write_reg(REG_STRIDE_OUTER, CFG_DATA_W'(so));
		write_reg(REG_STRIDE_MIDDLE, CFG_DATA_W'(sm));
		write_reg(REG_STRIDE_INNER, CFG_DATA_W'(si));
		cfg_write_enable <= 1'b0;
	endtask

	task automatic send_word(input logic [VALUE_W-1:0] value, input logic fresh);
		if (gaps_on) begin
			while ($urandom_range(99) < 26) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		fill_value <= value;
		restart <= fresh;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// drop valid and wait until every predicted word has come out
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (words_in_flight != 0)
			@(posedge clk);
	endtask

	task automatic run_items(input int count, input int restart_pct);
		for (int i = 0; i < count; i++)
			send_word({$urandom, $urandom}, $urandom_range(99) < restart_pct);
		drain();
	endtask

	function automatic logic [EXT_CFG_W-1:0] rand_extent;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return EXTENT_MAX;
			2: return EXT_CFG_W'($urandom);
			default: return EXT_CFG_W'($urandom_range(1, 4));
		endcase
	endfunction

	function automatic logic [STRIDE_W-1:0] rand_step;
		case ($urandom_range(0, 3))
			0: return '0;
			1: return STRIDE_MAX;
			2: return STRIDE_W'($urandom);
			default: return STRIDE_W'($urandom_range(1, 16));
		endcase
	endfunction

	// receiver, in a loop: random stalls, one long hold-off while words are offered, then a clean run
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			repeat (250) begin
				out_ready <= ($urandom_range(99) >= 26);
				@(posedge clk);
			end
			while (!in_valid) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
			for (int held = 0; held < 60; held++) begin
				out_ready <= 1'b0;
				@(posedge clk);
			end
			repeat (150) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
			@(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int random_items;
		int phase_no;
		int count;
		arst_n = 1'b0;
		cfg_write_enable = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		fill_value = '0;
		restart = 1'b0;
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset view: a single element, every word is the last one
		send_word('0, 1'b0);
		send_word('1, 1'b1);
		send_word({4{16'hAAAA}}, 1'b0);
		send_word({4{16'h5555}}, 1'b1);
		drain();

		// 2x2x2 view at the top of the base range, wraps once
		program_view(1'b0, BASE_MAX, EXT_CFG_W'(2), EXT_CFG_W'(2), EXT_CFG_W'(2),
			STRIDE_MAX, '0, STRIDE_W'(1));
		run_items(8, 0);

		// contiguous, zero extents on the outer dims, restart inside the pass
		program_view(1'b1, '0, '0, '0, EXT_CFG_W'(3), '0, '0, '0);
		send_word({$urandom, $urandom}, 1'b0);
		send_word({$urandom, $urandom}, 1'b1);
		send_word({$urandom, $urandom}, 1'b0);
		send_word({$urandom, $urandom}, 1'b0);
		drain();

		// inner extent shrinks mid-pass
		program_view(1'b0, BASE_W'(100), EXT_CFG_W'(1), EXT_CFG_W'(1), EXT_CFG_W'(5),
			'0, '0, STRIDE_W'(7));
		run_items(3, 0);
		write_reg(REG_EXTENT_INNER, CFG_DATA_W'(2));
		cfg_write_enable <= 1'b0;
		run_items(3, 0);

		// long outer walk at maximum stride runs past 32 address bits
		program_view(1'b0, BASE_MAX, EXTENT_MAX, EXT_CFG_W'(1), EXT_CFG_W'(1),
			STRIDE_MAX, '0, '0);
		run_items(300, 0);
		random_items = 300;

		phase_no = 0;
		while (random_items < RANDOM_ITEMS) begin
			program_view($urandom_range(0, 3) == 0, rand_step(), rand_extent(), rand_extent(),
				rand_extent(), rand_step(), rand_step(), rand_step());
			count = $urandom_range(20, 60);
			gaps_on = (phase_no != 2);
			if (!gaps_on)
				count = 80;
			run_items(count, 5);
			random_items += count;
			phase_no++;
		end
		gaps_on = 1'b1;

		repeat (8) @(posedge clk);
		if (mismatches == 0 && words_in_flight == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
